// ===== design/capture_block_packet_locator_defines.svh =====
// Assertion macros for the capture block packet locator.
`ifndef CAPTURE_BLOCK_PACKET_LOCATOR_DEFINES_SVH
`define CAPTURE_BLOCK_PACKET_LOCATOR_DEFINES_SVH

`ifndef SYNTH
`define CBPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cbpl assertion failed");
`define CBPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cbpl assertion failed");
`else
`define CBPL_ASSERT_NOW(label, ante, cons)
`define CBPL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/cbpl_pkg.sv =====
// Types and constants shared by the capture block packet locator modules.
package cbpl_pkg;

    localparam int DEFAULT_OFFSET_WIDTH = 32;

    localparam logic [31:0] TYPE_EPB = 32'h0000_0006;
    localparam logic [31:0] TYPE_SPB = 32'h0000_0003;

    localparam int HEADER_LEN   = 12;
    localparam int EPB_MIN_LEN  = 32;
    localparam int SPB_MIN_LEN  = 16;
    localparam int EPB_DATA_OFF = 28;
    localparam int SPB_DATA_OFF = 12;

    // byte positions relative to the block start
    localparam int LEN_REL      = 4;
    localparam int LEN_LAST_REL = 7;
    localparam int SPB_SIZE_REL = 8;
    localparam int SPB_LAST_REL = 11;
    localparam int EPB_SIZE_REL = 20;
    localparam int EPB_LAST_REL = 23;
    localparam int WORD_BYTES   = 4;

    localparam int M_TDATA_W = 104;

    typedef enum logic {
        RESULT_PACKET  = 1'b0,
        RESULT_SUMMARY = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t kind;
        logic [31:0]  packet_offset;
        logic [31:0]  packet_size;
        logic [31:0]  packet_count;
        logic         stopped_malformed;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
    } byte_item_t;

    typedef struct packed {
        logic    valid;
        result_t result;
    } result_item_t;

endpackage

// ===== design/cbpl_in_stage.sv =====
// Input register stage: holds one byte until the walker takes it.
module cbpl_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                proc_ok,
    output cbpl_pkg::byte_item_t item
);
    import cbpl_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       s_fire;
    logic       proc;

    assign proc          = valid_reg && proc_ok;
    assign s_axis_tready = !valid_reg || proc_ok;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (proc) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byte_reg <= s_axis_tdata;
        end
    end

    assign item.valid     = proc;
    assign item.data_byte = byte_reg;

endmodule

// ===== design/cbpl_walker.sv =====
// Block walker: tracks block boundaries and decodes packet locations per byte.
module cbpl_walker #(
    parameter int OFFSET_WIDTH = cbpl_pkg::DEFAULT_OFFSET_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  cbpl_pkg::byte_item_t   item,
    output cbpl_pkg::result_item_t res
);
    import cbpl_pkg::*;

    localparam int OW = OFFSET_WIDTH;
    localparam int SW = ((OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32) + 1;

    logic [31:0]   len_reg;
    logic [OW-1:0] pos_reg,    pos_next;
    logic [OW-1:0] bs_reg,     bs_next;
    logic [31:0]   type_reg,   type_next;
    logic [31:0]   length_reg, length_next;
    logic [31:0]   size_reg,   size_next;
    logic [31:0]   count_reg,  count_next;
    logic          stopped_reg, stopped_next;

    logic [SW-1:0] pos_ext, bs_ext, len_ext, rel, pos_plus1;
    logic [31:0]   len_sh, size_sh;
    logic          in_range, parse, last, hit, bad_len;
    logic          spb_hit, epb_hit;
    logic [OW-1:0] off_sum;
    logic [SW-1:0] off_ext;

    always_comb begin
        pos_ext   = SW'(pos_reg);
        bs_ext    = SW'(bs_reg);
        len_ext   = SW'(len_reg);
        rel       = pos_ext - bs_ext;
        pos_plus1 = pos_ext + SW'(1);
        in_range  = pos_ext < len_ext;
        last      = pos_plus1 == len_ext;
        parse     = !stopped_reg && (pos_ext >= bs_ext)
                    && (bs_ext + SW'(HEADER_LEN) <= len_ext);
        len_sh    = {item.data_byte, length_reg[31:8]};
        size_sh   = {item.data_byte, size_reg[31:8]};
        bad_len   = (len_sh < 32'(HEADER_LEN)) || (bs_ext + SW'(len_sh) > len_ext);
        spb_hit   = (rel == SW'(SPB_LAST_REL)) && (type_reg == TYPE_SPB)
                    && (length_reg >= 32'(SPB_MIN_LEN));
        epb_hit   = (rel == SW'(EPB_LAST_REL)) && (type_reg == TYPE_EPB)
                    && (length_reg >= 32'(EPB_MIN_LEN));
    end

    always_comb begin
        pos_next     = pos_reg;
        bs_next      = bs_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        hit          = 1'b0;
        off_sum      = bs_reg + OW'(SPB_DATA_OFF);
        if (item.valid && in_range) begin
            pos_next = pos_reg + OW'(1);
            if (parse) begin
                if (rel < SW'(LEN_REL)) begin
                    type_next = {item.data_byte, type_reg[31:8]};
                end else if (rel < SW'(SPB_SIZE_REL)) begin
                    length_next = len_sh;
                    if (rel == SW'(LEN_LAST_REL) && bad_len) begin
                        stopped_next = 1'b1;
                    end
                end else begin
                    if (rel < SW'(SPB_SIZE_REL + WORD_BYTES)
                        || (rel >= SW'(EPB_SIZE_REL)
                            && rel < SW'(EPB_SIZE_REL + WORD_BYTES))) begin
                        size_next = size_sh;
                    end
                    if (spb_hit) begin
                        hit = 1'b1;
                    end else if (epb_hit) begin
                        hit     = 1'b1;
                        off_sum = bs_reg + OW'(EPB_DATA_OFF);
                    end
                    if (hit) begin
                        count_next = count_reg + 32'd1;
                    end
                    // advance to the next block on its last byte
                    if (rel + SW'(1) == SW'(length_reg)) begin
                        bs_next = bs_reg + OW'(length_reg);
                    end
                end
            end
        end
    end

    always_comb begin
        off_ext                      = SW'(off_sum);
        res.valid                    = item.valid && in_range && (hit || last);
        res.result.kind              = RESULT_PACKET;
        res.result.packet_offset     = off_ext[31:0];
        res.result.packet_size       = size_next;
        res.result.packet_count      = count_next;
        res.result.stopped_malformed = 1'b0;
        if (!hit) begin
            res.result.kind              = RESULT_SUMMARY;
            res.result.packet_offset     = '0;
            res.result.packet_size       = '0;
            res.result.stopped_malformed = stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            pos_reg     <= '0;
            bs_reg      <= '0;
            type_reg    <= '0;
            length_reg  <= '0;
            size_reg    <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                len_reg <= cfg_wdata;
            end
            pos_reg     <= pos_next;
            bs_reg      <= bs_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            size_reg    <= size_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ===== design/cbpl_out_stage.sv =====
// Result register stage: holds one result until the downstream side takes it.
module cbpl_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cbpl_pkg::result_item_t     res,
    output logic                       proc_ok,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [cbpl_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                       m_axis_tuser
);
    import cbpl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign proc_ok = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res.valid) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            data_reg <= res.result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tdata  = {7'b0, data_reg.stopped_malformed, data_reg.packet_count,
                            data_reg.packet_size, data_reg.packet_offset};

endmodule

// ===== design/capture_block_packet_locator.sv =====
// Capture block packet locator top level: walks length-prefixed capture blocks.
//
//  channel   dir  payload                                          handshake
//  s_axis    in   tdata[7:0] data_byte                             tvalid/tready
//  m_axis    out  tdata: offset, size, count, stopped; tuser kind  tvalid/tready
//  cfg       in   cfg_wdata[31:0] buffer_length                    cfg_we
//
// One byte per cycle sustained while m_axis does not stall; a result passes from the
// input register through the walker's compare/add logic into the result register.
// Reset clears the scan state and buffer_length; no clearing pass is needed.
// A stalled m_axis holds the result; s_axis still takes one byte into the input
// register before tready drops.
`include "capture_block_packet_locator_defines.svh"

module capture_block_packet_locator #(
    parameter int OFFSET_WIDTH = cbpl_pkg::DEFAULT_OFFSET_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [31:0]                    cfg_wdata,     // buffer_length
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] packet_offset, [63:32] packet_size, [95:64] packet_count,
    // [96] stopped_malformed, [103:97] zero
    output logic [cbpl_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser   // result_kind
);
    import cbpl_pkg::*;

    byte_item_t   item;
    result_item_t res;
    logic         proc_ok;

    cbpl_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .proc_ok       (proc_ok),
        .item          (item)
    );

    cbpl_walker #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .res       (res)
    );

    cbpl_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res           (res),
        .proc_ok       (proc_ok),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `CBPL_ASSERT_NOW(a_ready_low_only_on_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `CBPL_ASSERT_NEXT(a_stall_keeps_result, !s_axis_tready, m_axis_tvalid)
    `CBPL_ASSERT_NOW(a_summary_has_no_location, m_axis_tvalid && (m_axis_tuser == RESULT_SUMMARY), m_axis_tdata[63:0] == 64'd0)
    `CBPL_ASSERT_NOW(a_packet_not_stopped, m_axis_tvalid && (m_axis_tuser == RESULT_PACKET), !m_axis_tdata[96])

endmodule
